@@ sv/weighted_random_sample_hold_top_macros.svh @@
// Assertion shorthands, clocked on i_clk and quiet in reset.
`ifndef WEIGHTED_RANDOM_SAMPLE_HOLD_TOP_MACROS_SVH
`define WEIGHTED_RANDOM_SAMPLE_HOLD_TOP_MACROS_SVH

// Same-cycle implication.
`define WRSH_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define WRSH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/wrsh_pkg.sv @@
`timescale 1ns / 1ps

package wrsh_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam int CUM_W    = 28;   // cumulative weight width
    localparam int WEIGHT_W = 16;
    localparam int VAL_W    = 32;   // Q16.16 word
    localparam int PERIOD_W = 24;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic [31:0]         LFSR_MASK  = 32'h8020_0003;
    localparam logic [31:0]         LFSR_SEED  = 32'hFFFF_FFFF;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(50);
    localparam logic [VAL_W-1:0]    SAT_MAX    = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        FUNC_CLEAR   = 2'd0,
        FUNC_APPEND  = 2'd1,
        FUNC_SAMPLE  = 2'd2,
        FUNC_RESTART = 2'd3
    } t_func;

    localparam logic [2:0] REG_PERIOD   = 3'd0;
    localparam logic [2:0] REG_NORM_LIM = 3'd1;
    localparam logic [2:0] REG_DEFAULT  = 3'd2;
    localparam logic [2:0] REG_ACTIVE   = 3'd3;
    localparam logic [2:0] REG_EXT_TRIG = 3'd4;

    // Divider status back to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

@@ sv/wrsh_ram.sv @@
`timescale 1ns / 1ps

module wrsh_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/wrsh_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module wrsh_div #(
    parameter int DW = 45,
    parameter int VW = 13
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DW-1:0]       i_dividend,
    input  logic [VW-1:0]       i_divisor,
    output wrsh_pkg::t_div_stat o_stat,
    output logic [DW-1:0]       o_quot
);

    import wrsh_pkg::*;

    localparam int CNTW = $clog2(DW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [VW-1:0]   r_rem;
    logic [DW-1:0]   r_q;
    logic [VW-1:0]   r_dv;

    logic [VW:0] w_rem_sh;
    logic [VW:0] w_diff;
    logic        w_ge;

    assign w_rem_sh = {r_rem, r_q[DW-1]};
    assign w_ge     = w_rem_sh >= {1'b0, r_dv};
    assign w_diff   = w_rem_sh - {1'b0, r_dv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(DW);
                r_rem  <= '0;
                r_q    <= i_dividend;
                r_dv   <= i_divisor;
            end else if (r_busy) begin
                // remainder stays below the divisor, so VW bits hold it
                r_rem <= w_ge ? w_diff[VW-1:0] : w_rem_sh[VW-1:0];
                r_q   <= {r_q[DW-2:0], w_ge};
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_q;

endmodule

@@ sv/weighted_random_sample_hold_top.sv @@
`timescale 1ns / 1ps

// Weighted random sample-and-hold. Weights are appended one word at a time
// (func 1) into a cumulative table in block RAM; func 0 empties the list,
// func 3 reloads the draw countdown from the period register, and func 2
// carries an audio sample and returns exactly one output word. On a sample
// the block draws when the countdown runs out (internal mode) or on a
// rising zero crossing (external mode). A draw steps a 32-bit Galois LFSR,
// scales it by the total weight and binary-searches the table for the first
// entry at or above that target; the index is held as Q16.16, or as
// max * index / count (saturated) when the normalization maximum is nonzero.
// While inactive with a non-empty list the output is default_out. A draw's
// binary search is paced by its read/compare step pair (S_RD, S_CMP)
// against the registered RAM port; with normalization the draw also passes
// through the shared multiplier and the bit-serial divider, whose dividend
// is 32 + count width bits wide. The input side stalls for the whole of a
// sample word; a finished word may wait in the output register while the
// next input word is taken.
`include "weighted_random_sample_hold_top_macros.svh"

module weighted_random_sample_hold_top #(
    parameter int TABLE_DEPTH = wrsh_pkg::TABLE_DEPTH_DEF,
    parameter int SAMPLE_BITS = wrsh_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input words
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_func,
    input  logic [wrsh_pkg::WEIGHT_W-1:0]   i_weight,
    input  logic signed [SAMPLE_BITS-1:0]   i_sample,
    // output words
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic signed [wrsh_pkg::VAL_W-1:0] o_value,
    output logic                            o_drew,
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wrsh_pkg::ADDR_W-1:0]     paddr,
    input  logic [wrsh_pkg::DATA_W-1:0]     pwdata,
    output logic [wrsh_pkg::DATA_W-1:0]     prdata,
    output logic                            pready
);

    import wrsh_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);     // table address
    localparam int CW = $clog2(TABLE_DEPTH + 1); // entry count, 0..depth
    localparam int DW = VAL_W + CW;              // scale maximum * index
    localparam int PW = CW + 16;                 // index as Q16.16

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_TGT,
        S_RD,
        S_CMP,
        S_DGO,
        S_DWAIT,
        S_PUSH
    } t_state;

    // ---------------- configuration registers ----------------
    logic [PERIOD_W-1:0] r_period;
    logic [VAL_W-1:0]    r_norm;
    logic [VAL_W-1:0]    r_default;
    logic                r_active;
    logic                r_ext;
    logic                w_cfg_wr;
    logic [2:0]          w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_cfg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= PERIOD_RST;
            r_norm    <= '0;
            r_default <= '0;
            r_active  <= 1'b1;
            r_ext     <= 1'b0;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                REG_PERIOD:   r_period  <= pwdata[PERIOD_W-1:0];
                REG_NORM_LIM: r_norm    <= pwdata;
                REG_DEFAULT:  r_default <= pwdata;
                REG_ACTIVE:   r_active  <= pwdata[0];
                REG_EXT_TRIG: r_ext     <= pwdata[0];
                default: ;  // unmapped, write dropped
            endcase
        end
    end

    always_comb begin
        unique case (w_cfg_idx)
            REG_PERIOD:   prdata = DATA_W'(r_period);
            REG_NORM_LIM: prdata = r_norm;
            REG_DEFAULT:  prdata = r_default;
            REG_ACTIVE:   prdata = DATA_W'(r_active);
            REG_EXT_TRIG: prdata = DATA_W'(r_ext);
            default:      prdata = '0;
        endcase
    end

    // ---------------- sequencer state ----------------
    t_state                  r_state;
    logic [CW-1:0]           r_count;      // entries in the list
    logic [CUM_W-1:0]        r_total;      // running weight sum
    logic [PERIOD_W-1:0]     r_countdown;
    logic [VAL_W-1:0]        r_held;
    logic signed [SAMPLE_BITS-1:0] r_last;
    logic [31:0]             r_lfsr;

    // shared multiplier operands and product
    logic [31:0]             r_mul_a;
    logic [31:0]             r_mul_b;
    logic [63:0]             r_prod;
    logic                    r_norm_phase; // product is scale maximum * index

    // search window
    logic [CUM_W-1:0]        r_target;
    logic [CW-1:0]           r_lo;
    logic [CW-1:0]           r_hi;
    logic [CW-1:0]           r_mid;

    // pending result and output register
    logic [VAL_W-1:0]        r_res_value;
    logic                    r_res_drew;
    logic                    r_out_valid;
    logic [VAL_W-1:0]        r_out_value;
    logic                    r_out_drew;

    // ---------------- datapath helpers ----------------
    logic                    w_accept;
    logic                    w_append;
    logic [CUM_W-1:0]        w_total_next;
    logic [31:0]             n_lfsr;
    logic                    w_last_le0;
    logic                    w_smp_gt0;
    logic                    w_cd_expired;
    logic                    w_do_draw;
    logic                    w_empty;
    logic [CW:0]             w_mid_sum;
    logic [CW-1:0]           w_mid;
    logic                    w_search_on;
    logic                    w_in_search;
    logic [64:0]             w_tsum;
    logic [PW-1:0]           w_idx_q16;
    logic [VAL_W-1:0]        w_sat;
    logic [CUM_W-1:0]        w_ram_rdata;
    logic                    w_out_free;
    logic                    w_push_go;

    logic [DW-1:0]           w_quot;
    t_div_stat               w_div_stat;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_empty    = (r_count == '0);
    assign w_append   = w_accept && (t_func'(i_func) == FUNC_APPEND)
                        && (r_count < CW'(TABLE_DEPTH));
    assign w_total_next = r_total + CUM_W'(i_weight);  // wraps at 28 bits

    // Galois step, right shift
    assign n_lfsr = (r_lfsr >> 1) ^ (r_lfsr[0] ? LFSR_MASK : 32'h0);

    assign w_last_le0   = r_last[SAMPLE_BITS-1] || (r_last == '0);
    assign w_smp_gt0    = !i_sample[SAMPLE_BITS-1] && (i_sample != '0);
    assign w_cd_expired = (r_countdown <= PERIOD_W'(1));
    assign w_do_draw    = r_ext ? (w_last_le0 && w_smp_gt0) : w_cd_expired;

    assign w_mid_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid       = w_mid_sum[CW:1];
    assign w_search_on = (r_state == S_RD) && (r_lo < r_hi);
    assign w_in_search = (r_state == S_RD) || (r_state == S_CMP);

    // ceil(total * u / 2^32); never above total, so 28 bits suffice
    assign w_tsum = {1'b0, r_prod} + 65'h0_FFFF_FFFF;

    assign w_idx_q16 = {r_lo, 16'h0};
    assign w_sat     = (|w_quot[DW-1:VAL_W-1]) ? SAT_MAX : w_quot[VAL_W-1:0];

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_push_go  = (r_state == S_PUSH) && w_out_free;

    wrsh_ram #(
        .WIDTH (CUM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_append),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (w_total_next),
        .i_re    (w_search_on),
        .i_raddr (w_mid[AW-1:0]),
        .o_rdata (w_ram_rdata)
    );

    wrsh_div #(
        .DW (DW),
        .VW (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DGO),
        .i_dividend (r_prod[DW-1:0]),
        .i_divisor  (r_count),
        .o_stat     (w_div_stat),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_total     <= '0;
            r_countdown <= '0;
            r_held      <= '0;
            r_last      <= '0;
            r_lfsr      <= LFSR_SEED;
            r_out_valid <= 1'b0;
        end else begin
            // in S_PUSH the output register is handled by the push arm
            if (r_out_valid && !i_out_stall && (r_state != S_PUSH)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        unique case (t_func'(i_func))
                            FUNC_CLEAR: begin
                                r_count <= '0;
                                r_total <= '0;
                            end
                            FUNC_APPEND: begin
                                if (w_append) begin
                                    r_total <= w_total_next;
                                    r_count <= r_count + CW'(1);
                                end
                            end
                            FUNC_RESTART: begin
                                r_countdown <= r_period;
                            end
                            FUNC_SAMPLE: begin
                                // an empty list counts as active
                                if (!r_active && !w_empty) begin
                                    r_res_value <= r_default;
                                    r_res_drew  <= 1'b0;
                                    r_state     <= S_PUSH;
                                end else begin
                                    if (r_ext) begin
                                        r_last <= i_sample;
                                    end else if (w_cd_expired) begin
                                        r_countdown <= r_period;
                                    end else begin
                                        r_countdown <= r_countdown - PERIOD_W'(1);
                                    end
                                    r_res_drew <= w_do_draw;
                                    if (!w_do_draw) begin
                                        r_res_value <= r_held;
                                        r_state     <= S_PUSH;
                                    end else begin
                                        r_lfsr <= n_lfsr;
                                        if (w_empty) begin
                                            r_held      <= '0;
                                            r_res_value <= '0;
                                            r_state     <= S_PUSH;
                                        end else begin
                                            r_mul_a      <= 32'(r_total);
                                            r_mul_b      <= n_lfsr;
                                            r_norm_phase <= 1'b0;
                                            r_state      <= S_MUL;
                                        end
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_MUL: begin
                    r_prod  <= r_mul_a * r_mul_b;
                    r_state <= r_norm_phase ? S_DGO : S_TGT;
                end
                S_TGT: begin
                    r_target <= w_tsum[32 +: CUM_W];
                    r_lo     <= '0;
                    r_hi     <= r_count;
                    r_state  <= S_RD;
                end
                S_RD: begin
                    if (r_lo < r_hi) begin
                        r_mid   <= w_mid;
                        r_state <= S_CMP;
                    end else if (r_norm == '0) begin
                        r_held      <= VAL_W'(w_idx_q16);
                        r_res_value <= VAL_W'(w_idx_q16);
                        r_state     <= S_PUSH;
                    end else begin
                        r_mul_a      <= r_norm;
                        r_mul_b      <= 32'(r_lo);
                        r_norm_phase <= 1'b1;
                        r_state      <= S_MUL;
                    end
                end
                S_CMP: begin
                    // first entry at or above target lies in [lo, hi]
                    if (w_ram_rdata < r_target) begin
                        r_lo <= r_mid + CW'(1);
                    end else begin
                        r_hi <= r_mid;
                    end
                    r_state <= S_RD;
                end
                S_DGO: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (w_div_stat.done) begin
                        r_held      <= w_sat;
                        r_res_value <= w_sat;
                        r_state     <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= r_res_value;
                        r_out_drew  <= r_res_drew;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = $signed(r_out_value);
    assign o_drew      = r_out_drew;

    // ---------------- checks ----------------
    `WRSH_ASSERT(a_window, w_in_search, (r_lo <= r_hi) && (r_hi <= r_count), "search window")
    `WRSH_ASSERT(a_div_done_wait, w_div_stat.done, r_state == S_DWAIT, "stray divider done")
    `WRSH_ASSERT(a_div_idle, r_state == S_IDLE, !w_div_stat.busy, "divider busy when idle")
    `WRSH_ASSERT_NEXT(a_push, w_push_go, r_out_valid && r_state == S_IDLE, "word not loaded")

endmodule
